// ===== src/u2u_pkg.sv =====
// Shared types and constants for the UTF-8 to UTF-16 decoder core.
// Used by u2u_decode, u2u_serial and utf8_to_utf16_decoder_core; no dependencies.
package u2u_pkg;

    localparam logic [15:0] REPL_UNIT     = 16'hFFFD;
    localparam logic [7:0]  LEAD_MIN      = 8'hC2;
    localparam logic [7:0]  LEAD_MAX      = 8'hF4;
    localparam logic [7:0]  LEAD_3B       = 8'hE0;
    localparam logic [7:0]  LEAD_ED       = 8'hED;
    localparam logic [7:0]  LEAD_4B       = 8'hF0;
    localparam logic [7:0]  CONT_LO       = 8'h80;
    localparam logic [7:0]  CONT_HI       = 8'hBF;
    localparam logic [7:0]  CONT_E0_LO    = 8'hA0;
    localparam logic [7:0]  CONT_ED_HI    = 8'h9F;
    localparam logic [7:0]  CONT_F0_LO    = 8'h90;
    localparam logic [7:0]  CONT_F4_HI    = 8'h8F;
    localparam logic [23:0] SUPP_BASE     = 24'h010000;
    localparam logic [5:0]  HI_SURR_TAG   = 6'b110110;
    localparam logic [5:0]  LO_SURR_TAG   = 6'b110111;
    localparam int          MAX_UNITS     = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_source;
    } t_in_item;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        last_unit;
    } t_out_item;

    // Open sequence: lead byte (zero when none), bytes taken, payload bits.
    typedef struct packed {
        logic [7:0]  pending_lead;
        logic [1:0]  bytes_seen;
        logic [17:0] partial_bits;
    } t_seq_state;

    // All code units caused by one input byte.
    typedef struct packed {
        logic [1:0]                  count;
        logic [MAX_UNITS-1:0][15:0]  units;
        logic                        last;
    } t_unit_bundle;

endpackage

// ===== src/utf8_to_utf16_decoder_core.sv =====
// UTF-8 to UTF-16 decoder core with U+FFFD replacement at maximal subparts.
// Depends on u2u_pkg, u2u_decode and u2u_serial.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+----------------------------------
//   in      | input     | i_in_valid / o_in_stall   | i_in_data : data_byte, end_of_source
//   out     | output    | o_out_valid / i_out_stall | o_out_data: code_unit, last_unit
//
// One byte is accepted per cycle while o_in_stall is low; its zero to two code units
// appear in the next cycle and leave at one transaction per cycle unless i_out_stall is
// high. The one-entry unit register holds the next byte back until all units are taken.
// Reset (i_rst_n low at a clock edge) closes any open sequence and empties the output.
// o_in_stall rises only while units remain that will not all be delivered this cycle.
module utf8_to_utf16_decoder_core
    import u2u_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    // Open UTF-8 sequence carried from one byte to the next.
    t_seq_state   r_seq;
    t_seq_state   n_seq;
    t_unit_bundle bundle;
    logic         free;
    logic         in_take;

    // A byte enters whenever the unit register is empty or drains this cycle.
    assign o_in_stall = !free;
    assign in_take    = i_in_valid && free;

    // The decode step is a short combinational path from the sequence register
    // and the incoming byte to the unit register.
    u2u_decode u_decode (
        .i_state  (r_seq),
        .i_item   (i_in_data),
        .o_bundle (bundle),
        .o_state  (n_seq)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= '0;
        end else if (in_take) begin
            r_seq <= n_seq;
        end
    end

    // The unit register serializes the transaction's units onto the output.
    u2u_serial u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (in_take),
        .i_bundle    (bundle),
        .o_free      (free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // The end of the source always closes the sequence.
    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && i_in_data.end_of_source) |=> (r_seq.pending_lead == 8'h00))
        else $error("sequence left open after end of source");

endmodule

// ===== src/u2u_decode.sv =====
// Combinational UTF-8 step: sequence state plus one byte gives the code units
// and the next state. Depends on u2u_pkg.
module u2u_decode
    import u2u_pkg::*;
(
    input  t_seq_state   i_state,
    input  t_in_item     i_item,
    output t_unit_bundle o_bundle,
    output t_seq_state   o_state
);

    logic [7:0]  b;
    logic        open_seq;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic        cont_ok;
    logic [23:0] cp;
    logic [20:0] v;
    logic        seq_done;
    logic [17:0] lead_bits;
    logic [1:0]  cnt;
    t_seq_state  st;

    always_comb begin
        b        = i_item.data_byte;
        open_seq = (i_state.pending_lead != 8'h00);
        lo       = CONT_LO;
        hi       = CONT_HI;
        if (i_state.bytes_seen == 2'd1) begin
            if (i_state.pending_lead == LEAD_3B)      lo = CONT_E0_LO;
            else if (i_state.pending_lead == LEAD_ED) hi = CONT_ED_HI;
            else if (i_state.pending_lead == LEAD_4B) lo = CONT_F0_LO;
            else if (i_state.pending_lead == LEAD_MAX) hi = CONT_F4_HI;
        end
        cont_ok  = (b >= lo) && (b <= hi);
        cp       = {i_state.partial_bits, b[5:0]};
        v        = cp[20:0] - SUPP_BASE[20:0];
        seq_done = (i_state.pending_lead < LEAD_3B)
                 || ((i_state.pending_lead < LEAD_4B) && (i_state.bytes_seen >= 2'd2))
                 || (i_state.bytes_seen == 2'd3);
        if (b < LEAD_3B)      lead_bits = {13'd0, b[4:0]};
        else if (b < LEAD_4B) lead_bits = {14'd0, b[3:0]};
        else                  lead_bits = {15'd0, b[2:0]};

        cnt             = 2'd0;
        o_bundle.units  = '0;
        o_bundle.last   = i_item.end_of_source;
        st              = i_state;

        if (open_seq && cont_ok) begin
            if (seq_done) begin
                if (cp < SUPP_BASE) begin
                    o_bundle.units[0] = cp[15:0];
                    cnt = 2'd1;
                end else begin
                    o_bundle.units[0] = {HI_SURR_TAG, v[19:10]};
                    o_bundle.units[1] = {LO_SURR_TAG, v[9:0]};
                    cnt = 2'd2;
                end
                st = '0;
            end else begin
                st.bytes_seen   = i_state.bytes_seen + 2'd1;
                st.partial_bits = cp[17:0];
            end
        end else begin
            // A broken sequence is replaced first, then the byte starts over as a lead.
            if (open_seq) begin
                o_bundle.units[0] = REPL_UNIT;
                cnt = 2'd1;
                st  = '0;
            end
            if (!b[7]) begin
                o_bundle.units[cnt] = {8'h00, b};
                cnt = cnt + 2'd1;
            end else if ((b < LEAD_MIN) || (b > LEAD_MAX)) begin
                o_bundle.units[cnt] = REPL_UNIT;
                cnt = cnt + 2'd1;
            end else begin
                st.pending_lead = b;
                st.bytes_seen   = 2'd1;
                st.partial_bits = lead_bits;
            end
        end

        // An unfinished sequence at the end of the source gives one replacement.
        if (i_item.end_of_source && (st.pending_lead != 8'h00)) begin
            o_bundle.units[cnt] = REPL_UNIT;
            cnt = cnt + 2'd1;
            st  = '0;
        end

        o_bundle.count = cnt;
        o_state        = st;
    end

endmodule

// ===== src/u2u_serial.sv =====
// Result register that holds the code units of one byte and hands them out
// one transaction at a time. Depends on u2u_pkg.
module u2u_serial
    import u2u_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_load,
    input  t_unit_bundle i_bundle,
    output logic         o_free,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output t_out_item    o_out_data
);

    logic [1:0]                 r_cnt;
    logic [1:0]                 r_idx;
    logic [MAX_UNITS-1:0][15:0] r_units;
    logic                       r_last;
    logic                       taken;
    logic                       final_take;

    assign o_out_valid          = (r_cnt != 2'd0);
    assign taken                = o_out_valid && !i_out_stall;
    assign final_take           = taken && (r_idx == r_cnt - 2'd1);
    assign o_free               = !o_out_valid || final_take;
    assign o_out_data.code_unit = r_units[r_idx];
    assign o_out_data.last_unit = r_last && (r_idx == r_cnt - 2'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_idx <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_bundle.count;
            r_idx <= 2'd0;
        end else if (final_take) begin
            r_cnt <= 2'd0;
            r_idx <= 2'd0;
        end else if (taken) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_units <= i_bundle.units;
            r_last  <= i_bundle.last;
        end
    end

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd0) |-> (r_idx < r_cnt))
        else $error("unit index beyond bundle count");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("bundle loaded over undelivered units");

    a_load_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> ((r_idx == 2'd0) && (r_cnt == $past(i_bundle.count))))
        else $error("loaded bundle does not start at its first unit");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall && !i_load) |=> ($stable(r_idx) && $stable(r_cnt)))
        else $error("unit position moved while output stalled");

endmodule

// ===== verif/utf8_to_utf16_decoder_core_checker.sv =====
// Scoreboard for the UTF-8 to UTF-16 decoder core: watches both channels,
// predicts the code units of every accepted byte and compares them in order.
// Depends on u2u_pkg for the channel payload types and the UTF-8 constants.
module utf8_to_utf16_decoder_core_checker
    import u2u_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_bytes,
    output int        o_units,
    output int        o_repl_units,
    output int        o_surr_units
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    // Open sequence as the decoder should hold it.
    logic [7:0]  seq_lead;
    logic [1:0]  seq_count;
    logic [17:0] seq_bits;

    t_out_item expected_units[$];
    t_out_item step_units[$];

    function automatic void push_unit(input logic [15:0] unit);
        step_units.push_back(t_out_item'({unit, 1'b0}));
    endfunction

    function automatic void clear_sequence();
        seq_lead  = 8'h00;
        seq_count = 2'd0;
        seq_bits  = 18'd0;
    endfunction

    function automatic void take_lead(input logic [7:0] b);
        if (b < CONT_LO) begin
            push_unit({8'h00, b});
        end else if (b < LEAD_MIN || b > LEAD_MAX) begin
            push_unit(REPL_UNIT);
        end else begin
            seq_lead  = b;
            seq_count = 2'd1;
            if (b < LEAD_3B) begin
                seq_bits = {13'd0, b[4:0]};
            end else if (b < LEAD_4B) begin
                seq_bits = {14'd0, b[3:0]};
            end else begin
                seq_bits = {15'd0, b[2:0]};
            end
        end
    endfunction

    // Works out the code units that one byte causes and queues them.
    function automatic void decode_byte(input t_in_item item);
        logic [7:0]  b;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [23:0] cp;
        logic [23:0] v;
        int          need;
        b = item.data_byte;
        step_units.delete();
        if (seq_lead == 8'h00) begin
            take_lead(b);
        end else begin
            lo = CONT_LO;
            hi = CONT_HI;
            if (seq_count == 2'd1) begin
                if (seq_lead == LEAD_3B) lo = CONT_E0_LO;
                else if (seq_lead == LEAD_ED) hi = CONT_ED_HI;
                else if (seq_lead == LEAD_4B) lo = CONT_F0_LO;
                else if (seq_lead == LEAD_MAX) hi = CONT_F4_HI;
            end
            if (b < lo || b > hi) begin
                // The open sequence is replaced, then the byte starts over as a lead.
                push_unit(REPL_UNIT);
                clear_sequence();
                take_lead(b);
            end else begin
                cp   = {seq_bits, b[5:0]};
                need = (seq_lead < LEAD_3B) ? 2 : (seq_lead < LEAD_4B) ? 3 : 4;
                if (int'(seq_count) + 1 >= need) begin
                    if (cp < SUPP_BASE) begin
                        push_unit(cp[15:0]);
                    end else begin
                        v = cp - SUPP_BASE;
                        push_unit({HI_SURR_TAG, v[19:10]});
                        push_unit({LO_SURR_TAG, v[9:0]});
                    end
                    clear_sequence();
                end else begin
                    seq_count = seq_count + 2'd1;
                    seq_bits  = cp[17:0];
                end
            end
        end
        if (item.end_of_source) begin
            if (seq_lead != 8'h00) begin
                push_unit(REPL_UNIT);
                clear_sequence();
            end
            if (step_units.size() > 0) step_units[step_units.size() - 1].last_unit = 1'b1;
        end
        foreach (step_units[i]) expected_units.push_back(step_units[i]);
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            clear_sequence();
            expected_units.delete();
        end else begin
            // A unit leaves only after its byte has been registered, so the output side
            // is settled before this cycle's byte adds new expectations.
            if (i_out_valid && !i_out_stall) begin
                o_units++;
                if (i_out_data.code_unit == REPL_UNIT) o_repl_units++;
                if (i_out_data.code_unit[15:11] == 5'b11011) o_surr_units++;
                if (expected_units.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_LIMIT)
                        $display("%0t: unexpected code unit %h last %b", $realtime,
                                 i_out_data.code_unit, i_out_data.last_unit);
                end else begin
                    want = expected_units.pop_front();
                    if (i_out_data.code_unit !== want.code_unit ||
                        i_out_data.last_unit !== want.last_unit) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_LIMIT)
                            $display("%0t: mismatch: expected unit %h last %b, got unit %h last %b",
                                     $realtime, want.code_unit, want.last_unit,
                                     i_out_data.code_unit, i_out_data.last_unit);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                o_bytes++;
                decode_byte(i_in_data);
            end
        end
        o_pending = expected_units.size();
    end

endmodule

// ===== verif/utf8_to_utf16_decoder_core_tb.sv =====
// Top of the UTF-8 to UTF-16 decoder core testbench: clock, reset, byte stimulus,
// random output back-pressure, watchdog and verdict.
// Depends on u2u_pkg, utf8_to_utf16_decoder_core and utf8_to_utf16_decoder_core_checker.
module utf8_to_utf16_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import u2u_pkg::*;

    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_BYTES  = 350;
    localparam int IDLE_PERCENT  = 23;
    localparam int DRAIN_CYCLES  = 20;
    // Cycles without any transaction on either channel before the run is declared hung.
    // Both sides idle independently at under a quarter of the cycles, so a correct
    // decoder never comes anywhere near this.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIR_LEN       = 26;

    // Directed bytes, each written as {data_byte, end_of_source}.
    localparam logic [8:0] DIRECTED [DIR_LEN] = '{
        // Smallest and largest ASCII, the second one closing a source.
        {8'h00, 1'b0}, {8'h7F, 1'b1},
        // Two-byte scalar U+00BF, the largest with lead byte C2.
        {8'hC2, 1'b0}, {8'hBF, 1'b0},
        // E0 followed by a byte below its allowed range: overlong, broken twice.
        {8'hE0, 1'b0}, {8'h9F, 1'b0},
        // ED followed by A0 would encode a surrogate.
        {8'hED, 1'b0}, {8'hA0, 1'b0},
        // F4 followed by 90 would go above U+10FFFF.
        {8'hF4, 1'b0}, {8'h90, 1'b0},
        // U+10000, the first surrogate pair.
        {8'hF0, 1'b0}, {8'h90, 1'b0}, {8'h80, 1'b0}, {8'h80, 1'b0},
        // U+10FFFF, the last surrogate pair, closing a source.
        {8'hF4, 1'b0}, {8'h8F, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b1},
        // Lead bytes that can never start a sequence.
        {8'hC1, 1'b0}, {8'hF5, 1'b0}, {8'hFF, 1'b0},
        // A two-byte sequence broken by ASCII.
        {8'hC3, 1'b0}, {8'h41, 1'b0},
        // A four-byte sequence broken by a new lead that the end of source leaves open.
        {8'hF0, 1'b0}, {8'h9F, 1'b0}, {8'hE2, 1'b1}
    };

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    // While set, neither side idles: one long stretch at full rate.
    logic      calm        = 1'b0;

    int        fail_count;
    int        pending_units;
    int        bytes_taken;
    int        units_taken;
    int        repl_units;
    int        surr_units;
    int        quiet_cycles = 0;

    t_in_item  byte_stream[$];

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    utf8_to_utf16_decoder_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    utf8_to_utf16_decoder_core_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_units),
        .o_bytes      (bytes_taken),
        .o_units      (units_taken),
        .o_repl_units (repl_units),
        .o_surr_units (surr_units)
    );

    // The receiving side stalls at random, changing only at the falling edge.
    always @(negedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    // Watchdog: any transaction on either channel restarts the count.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Each source byte ends the source now and then, which also lands on
    // bytes in the middle of a sequence.
    function automatic void add_byte(input logic [7:0] b);
        byte_stream.push_back(t_in_item'({b, $urandom_range(0, 15) == 0}));
    endfunction

    // Standard UTF-8 encoding of a scalar; returns the byte count.
    function automatic int encode_scalar(input logic [20:0] cp, output logic [7:0] enc [4]);
        enc = '{default: 8'h00};
        if (cp < 21'h80) begin
            enc[0] = cp[7:0];
            return 1;
        end else if (cp < 21'h800) begin
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
            return 2;
        end else if (cp < 21'h10000) begin
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
            return 3;
        end
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
        return 4;
    endfunction

    // A random scalar that needs two to four bytes, biased toward the leads
    // E0, ED, F0 and F4 whose second byte has a narrowed range.
    function automatic logic [20:0] pick_multibyte();
        logic [20:0] cp;
        case ($urandom_range(0, 7))
            0, 1: cp = 21'($urandom_range(32'h80, 32'h7FF));
            2:    cp = 21'($urandom_range(32'h800, 32'hFFF));
            3:    cp = 21'($urandom_range(32'hD000, 32'hD7FF));
            4: begin
                cp = 21'($urandom_range(32'h800, 32'hFFFF));
                if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp - 21'h800;
            end
            5:    cp = 21'($urandom_range(32'h10000, 32'h3FFFF));
            6:    cp = 21'($urandom_range(32'h100000, 32'h10FFFF));
            default: cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
        endcase
        return cp;
    endfunction

    // One random chunk: mostly well-formed characters, the rest noise,
    // cut-off sequences and leads followed by an arbitrary byte.
    function automatic void add_random_chunk();
        logic [7:0] enc [4];
        int         len;
        int         kind;
        kind = $urandom_range(0, 99);
        if (kind < 25) begin
            add_byte(8'($urandom_range(0, 127)));
        end else if (kind < 80) begin
            len = encode_scalar(pick_multibyte(), enc);
            for (int i = 0; i < len; i++) add_byte(enc[i]);
        end else if (kind < 87) begin
            add_byte(8'($urandom_range(0, 255)));
        end else if (kind < 94) begin
            len = encode_scalar(pick_multibyte(), enc);
            len = $urandom_range(1, len - 1);
            for (int i = 0; i < len; i++) add_byte(enc[i]);
        end else begin
            add_byte(8'($urandom_range(32'hC2, 32'hF4)));
            add_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    // Offers one byte: optional idle cycles first, then valid held with a
    // stable payload until the transaction completes. Called and returns at a
    // falling edge, so valid is never lowered and raised in the same step.
    task automatic send_byte(input t_in_item item);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        for (int i = 0; i < DIR_LEN; i++) byte_stream.push_back(t_in_item'(DIRECTED[i]));
        while (byte_stream.size() < DIR_LEN + RANDOM_BYTES) add_random_chunk();

        // Synchronous reset held over several rising edges, released once.
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // A window in the middle of the random part runs without any idling
        // on either side, so back-to-back bytes and units are exercised.
        foreach (byte_stream[i]) begin
            calm <= (i >= DIR_LEN + 120) && (i < DIR_LEN + 200);
            send_byte(byte_stream[i]);
        end
        i_in_valid <= 1'b0;
        calm       <= 1'b0;

        // Drain: every predicted unit must arrive; a lost unit trips the watchdog.
        // The extra cycles catch any unit the decoder emits beyond the prediction.
        while (pending_units != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Decoded %0d source bytes (edge cases, random UTF-8, broken and cut sequences)",
                 bytes_taken);
        $display("into %0d code units: %0d replacements, %0d surrogate halves, %0d failures",
                 units_taken, repl_units, surr_units, fail_count);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
